// File: hw/rtl/aedm_pkg.sv
// Shared constants, codes and word types for the echo delay mixer.
package aedm_pkg;

	// Sample and register widths
	localparam int SMP_W      = 16;
	localparam int DELAY_W    = 15;
	localparam int DIV_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// Default ring depth and register reset values
	localparam int AEDM_MAX_DELAY = 16384;
	localparam logic [DELAY_W-1:0] DELAY_RST   = DELAY_W'(8000);
	localparam logic [DIV_W-1:0]   DIVISOR_RST = DIV_W'(4);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_DELAY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIVISOR = 1'b1;

	// Command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	// Queue between front and back, and the most words the block can hold
	localparam int QUEUE_DEPTH  = 2;
	localparam int MAX_INFLIGHT = QUEUE_DEPTH + 3;

	typedef struct packed {
		logic                    command;
		logic signed [SMP_W-1:0] sample_in;
	} in_word_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample_out;
		logic                    tail_last;
	} out_word_t;

	// Classified word handed from front to back
	typedef struct packed {
		logic [SMP_W-1:0] smp;      // input sample, zero on a flush
		logic [SMP_W-1:0] echo_raw; // delayed sample before scaling
		logic             last;     // closes the tail
	} q_word_t;

endpackage

// File: hw/rtl/aedm_if.sv
// Valid/ready channel interfaces for input and result words.
interface aedm_in_if import aedm_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aedm_out_if import aedm_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/audio_echo_delay_mixer_unit.sv
// Feed-forward echo mixer on signed 16-bit PCM. Each accepted word gives exactly one result
// word: a sample word (command 0) returns the sample plus the sample from delay_samples words
// earlier divided by volume_divisor (truncating toward zero, sum wrapped to 16 bits); a flush
// word (command 1) stores a zero and returns the echo tail, with tail_last set on the flush
// that completes delay_samples flushes. The delay ring reads as zero after reset with no
// clearing pass, so words are taken right away. Register 0 is delay_samples (0 acts as 1,
// values above MAX_DELAY clamp), register 1 is volume_divisor (0 acts as 1); write them only
// while no word is in flight. The back part works on one word at a time: it takes the word from
// the queue, runs the 16 steps of the bit-serial divider, then loads the result register once
// that register is free, and only then takes the next word from the queue; the front part takes
// a word per cycle into a two-word queue until that queue backs up.
module audio_echo_delay_mixer_unit import aedm_pkg::*; #(
	parameter int MAX_DELAY = AEDM_MAX_DELAY
) (
	input  logic                  clk,
	input  logic                  arst_n,
	aedm_in_if.sink               in_ch,
	aedm_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DELAY_W-1:0] delay_q;
	logic [DIV_W-1:0]   divisor_q;

	logic    push;
	logic    full;
	logic    pop;
	logic    empty;
	q_word_t push_word;
	q_word_t pop_word;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q   <= DELAY_RST;
			divisor_q <= DIVISOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_IDX_DELAY:   delay_q   <= cfg_data[DELAY_W-1:0];
				CFG_IDX_DIVISOR: divisor_q <= cfg_data[DIV_W-1:0];
				default:         delay_q   <= delay_q;
			endcase
		end
	end

	aedm_front #(
		.MAX_DELAY(MAX_DELAY)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.delay     (delay_q),
		.push      (push),
		.push_word (push_word),
		.full      (full)
	);

	aedm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (full),
		.pop       (pop),
		.pop_word  (pop_word),
		.empty     (empty)
	);

	aedm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.divisor  (divisor_q),
		.pop      (pop),
		.pop_word (pop_word),
		.empty    (empty),
		.out_ch   (out_ch)
	);

endmodule

// File: hw/rtl/aedm_front.sv
// Front part: accepts words, keeps the delay ring and the tail count, reads the echo tap.
module aedm_front import aedm_pkg::*; #(
	parameter int MAX_DELAY = AEDM_MAX_DELAY
) (
	input  logic               clk,
	input  logic               arst_n,
	aedm_in_if.sink            in_ch,
	input  logic [DELAY_W-1:0] delay,
	output logic               push,
	output q_word_t            push_word,
	input  logic               full
);

	localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
	localparam int FW = $clog2(MAX_DELAY + 1);
	localparam int CW = (FW > DELAY_W) ? FW : DELAY_W;

	logic [SMP_W-1:0]   mem_q [MAX_DELAY];
	logic [AW-1:0]      pos_q;
	logic [FW-1:0]      fill_q;
	logic [DELAY_W-1:0] fc_q;

	logic               vld_s1;
	logic [SMP_W-1:0]   smp_s1;
	logic               last_s1;
	logic               hit_s1;
	logic [SMP_W-1:0]   rd_data_s1;

	logic               acc;
	logic               is_flush;
	logic [FW-1:0]      d_eff;
	logic [FW-1:0]      pos_ext;
	logic [FW-1:0]      diff;
	logic [FW-1:0]      diff_wrap;
	logic [AW-1:0]      rd_addr;
	logic [DELAY_W-1:0] fc_inc;
	logic               tail_hit;
	logic [SMP_W-1:0]   wr_smp;

	assign acc      = in_ch.valid && in_ch.ready;
	assign is_flush = (in_ch.data.command == CMD_FLUSH);
	assign wr_smp   = is_flush ? '0 : in_ch.data.sample_in;

	// Effective delay: zero reads as one, large values clamp to the ring depth
	always_comb begin
		priority if (delay == '0) begin
			d_eff = FW'(1);
		end else if (CW'(delay) > CW'(MAX_DELAY)) begin
			d_eff = FW'(MAX_DELAY);
		end else begin
			d_eff = FW'(delay);
		end
	end

	// Tap address, wrapped into the ring
	assign pos_ext   = FW'(pos_q);
	assign diff      = pos_ext - d_eff;
	assign diff_wrap = diff + FW'(MAX_DELAY);
	assign rd_addr   = (pos_ext >= d_eff) ? diff[AW-1:0] : diff_wrap[AW-1:0];

	// Tail counter
	assign fc_inc   = fc_q + 1'b1;
	assign tail_hit = (CW'(fc_inc) >= CW'(d_eff));

	// Handshake: the stage register frees as it pushes into the queue
	assign push         = vld_s1 && !full;
	assign in_ch.ready  = !vld_s1 || push;

	// Ring store, read before write
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_data_s1     <= mem_q[rd_addr];
			mem_q[pos_q]   <= wr_smp;
			smp_s1         <= wr_smp;
			last_s1        <= is_flush && tail_hit;
			hit_s1         <= (FW'(rd_addr) < fill_q);
		end
	end

	// Ring position, fill count, tail count and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
			fc_q   <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (acc) begin
				pos_q <= (pos_q == AW'(MAX_DELAY - 1)) ? '0 : pos_q + 1'b1;
				if (fill_q != FW'(MAX_DELAY)) begin
					fill_q <= fill_q + 1'b1;
				end
				if (is_flush) begin
					fc_q <= tail_hit ? '0 : fc_inc;
				end else begin
					fc_q <= '0;
				end
				vld_s1 <= 1'b1;
			end else if (push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// Entries never written since reset read as zero
	assign push_word.smp      = smp_s1;
	assign push_word.echo_raw = hit_s1 ? rd_data_s1 : '0;
	assign push_word.last     = last_s1;

endmodule

// File: hw/rtl/aedm_queue.sv
// Two-word queue between the front and back parts.
module aedm_queue import aedm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_word_t push_word,
	output logic    full,
	input  logic    pop,
	output q_word_t pop_word,
	output logic    empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	q_word_t       ent_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;

	assign full     = (cnt_q == NW'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_word = ent_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/aedm_back.sv
// Back part: scales the echo with a bit-serial divider, mixes, holds the result word.
module aedm_back import aedm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [DIV_W-1:0] divisor,
	output logic             pop,
	input  q_word_t          pop_word,
	input  logic             empty,
	aedm_out_if.source       out_ch
);

	localparam int CNT_W = $clog2(SMP_W);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SMP_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;
	logic             neg_q;
	logic [SMP_W-1:0] smp_q;
	logic             last_q;
	logic             out_vld_q;
	out_word_t        out_word_q;

	logic [DIV_W+1:0] trial;
	logic             borrow;
	logic [SMP_W-1:0] echo;
	logic [SMP_W-1:0] mix;
	logic             load;

	// One restoring step per cycle
	assign trial  = {1'b0, rem_q, quo_q[SMP_W-1]} - {2'b00, dvs_q};
	assign borrow = trial[DIV_W+1];

	// Sign back on, then wrap-around mix
	assign echo = neg_q ? (SMP_W'(0) - quo_q) : quo_q;
	assign mix  = smp_q + echo;

	assign pop  = (state_q == ST_IDLE) && !empty;
	assign load = (state_q == ST_FIN) && (!out_vld_q || out_ch.ready);

	assign out_ch.valid = out_vld_q;
	assign out_ch.data  = out_word_q;

	// Sequencer, divider datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			quo_q      <= '0;
			rem_q      <= '0;
			dvs_q      <= '0;
			neg_q      <= 1'b0;
			smp_q      <= '0;
			last_q     <= 1'b0;
			out_vld_q  <= 1'b0;
			out_word_q <= '0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						neg_q   <= pop_word.echo_raw[SMP_W-1];
						quo_q   <= pop_word.echo_raw[SMP_W-1] ?
							(SMP_W'(0) - pop_word.echo_raw) : pop_word.echo_raw;
						rem_q   <= '0;
						dvs_q   <= (divisor == '0) ? DIV_W'(1) : divisor;
						smp_q   <= pop_word.smp;
						last_q  <= pop_word.last;
						cnt_q   <= CNT_W'(SMP_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= borrow ? {rem_q[DIV_W-2:0], quo_q[SMP_W-1]} : trial[DIV_W-1:0];
					quo_q <= {quo_q[SMP_W-2:0], !borrow};
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					if (load) begin
						out_word_q.sample_out <= mix;
						out_word_q.tail_last  <= last_q;
						state_q               <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/aedm_checker.sv
// Port-level checks on the echo mixer, bound to the top level.
module aedm_checker import aedm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	localparam int PW = $clog2(MAX_INFLIGHT + 1) + 1;

	logic [PW-1:0] pending_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Words accepted whose result has not been taken yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + PW'(in_acc) - PW'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result word changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result word without an accepted input word");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PW'(MAX_INFLIGHT))
		else $error("more words in flight than the block can hold");

endmodule

bind audio_echo_delay_mixer_unit aedm_checker u_aedm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
